### src/sgdwu_pkg.sv
// Shared constants, codes and helpers for the SGD weight update unit.
package sgdwu_pkg;

    localparam int DATA_W     = 32;
    localparam int SCALE_BITS = 24;
    localparam int CFG_IDX_W  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_MOMENTUM    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD_SCALE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_SCALE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM_FACTOR = 3'd4;

    // regularization codes
    localparam logic [1:0] REG_NONE = 2'd0;
    localparam logic [1:0] REG_L1   = 2'd1;
    localparam logic [1:0] REG_L2   = 2'd2;

    localparam int SUM_W = 42;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] val;
    } clamp_t;

    // clamp a wide signed sum to the signed 32-bit range
    function automatic clamp_t clamp32(input logic [SUM_W-1:0] s);
        clamp_t r;
        r.sat = !((&s[SUM_W-1:DATA_W-1]) || !(|s[SUM_W-1:DATA_W-1]));
        if (r.sat)
        begin
            r.val = s[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            r.val = s[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

### src/sgd_weight_update_unit.sv
// Top level: four-stage pipelined SGD weight update with momentum and L1/L2 decay.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: weight_in, velocity_in, gradient_sum
//  m_*     | out | m_tvalid/m_tready  | m_tdata: weight_out, velocity_out; m_tuser: saturated
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_data
//
// One word per cycle sustained while m_tready keeps up; m_tvalid is the stage 4 valid bit.
// Stage 1 holds the three scale multipliers, stage 2 the rounding shift,
// stage 3 the three-term sum and first clamp, stage 4 the momentum weight add.
// Reset clears the stage valid bits and the configuration registers.
// A stall at m_tready holds each full stage with no empty stage after it; empty stages keep filling.
module sgd_weight_update_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // weight_in, velocity_in, gradient_sum
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // weight_out, velocity_out
    output logic        m_tuser,   // saturated
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic signed [31:0] L1_ONE = 32'(64'd1 << FRAC_BITS);
    localparam logic [63:0] HALF_64 = 64'd1 << (sgdwu_pkg::SCALE_BITS - 1);
    localparam logic [56:0] HALF_57 = 57'd1 << (sgdwu_pkg::SCALE_BITS - 1);

    // configuration
    logic [1:0]  reg_mode_reg;
    logic        use_momentum_reg;
    logic [31:0] grad_scale_reg;
    logic [31:0] decay_scale_reg;
    logic [23:0] momentum_factor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_mode_reg        <= sgdwu_pkg::REG_NONE;
            use_momentum_reg    <= 1'b0;
            grad_scale_reg      <= '0;
            decay_scale_reg     <= '0;
            momentum_factor_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sgdwu_pkg::CFG_REG_MODE:        reg_mode_reg        <= cfg_data[1:0];
                sgdwu_pkg::CFG_USE_MOMENTUM:    use_momentum_reg    <= cfg_data[0];
                sgdwu_pkg::CFG_GRAD_SCALE:      grad_scale_reg      <= cfg_data;
                sgdwu_pkg::CFG_DECAY_SCALE:     decay_scale_reg     <= cfg_data;
                sgdwu_pkg::CFG_MOMENTUM_FACTOR: momentum_factor_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // stage control
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ld1, ld2, ld3, ld4;

    assign ld4      = !v4_reg || m_tready;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign s_tready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= s_tvalid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
            if (ld4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // stage 1: products
    logic signed [31:0] w_in, v_in, g_in;
    logic signed [31:0] d_op;
    logic signed [63:0] pg_full, pd_full;
    logic signed [56:0] pm_full;

    assign w_in = s_tdata[31:0];
    assign v_in = s_tdata[63:32];
    assign g_in = s_tdata[95:64];

    always_comb
    begin
        case (reg_mode_reg)
            sgdwu_pkg::REG_L1:
            begin
                if (w_in == 32'sd0)
                begin
                    d_op = 32'sd0;
                end
                else if (w_in[31])
                begin
                    d_op = -L1_ONE;
                end
                else
                begin
                    d_op = L1_ONE;
                end
            end
            sgdwu_pkg::REG_L2: d_op = w_in;
            default:           d_op = 32'sd0;
        endcase
    end

    assign pg_full = $signed({1'b0, grad_scale_reg}) * g_in;
    assign pd_full = $signed({1'b0, decay_scale_reg}) * d_op;
    assign pm_full = $signed({1'b0, momentum_factor_reg}) * v_in;

    logic [31:0] w1_reg, v1d_reg;
    logic [63:0] pg1_reg, pd1_reg;
    logic [56:0] pm1_reg;

    // stage 2: round half up and drop the scale fraction
    logic [63:0] pg_rnd, pd_rnd;
    logic [56:0] pm_rnd;

    assign pg_rnd = pg1_reg + HALF_64;
    assign pd_rnd = pd1_reg + HALF_64;
    assign pm_rnd = pm1_reg + HALF_57;

    logic [31:0] w2_reg, v2d_reg;
    logic [39:0] gt2_reg, dt2_reg;
    logic [32:0] mt2_reg;

    // stage 3: three-term sum, first clamp
    logic [sgdwu_pkg::SUM_W-1:0] base3, sum3;
    sgdwu_pkg::clamp_t           c3;

    assign base3 = use_momentum_reg ? {{9{mt2_reg[32]}}, mt2_reg} : {{10{w2_reg[31]}}, w2_reg};
    assign sum3  = base3 - {{2{gt2_reg[39]}}, gt2_reg} - {{2{dt2_reg[39]}}, dt2_reg};
    assign c3    = sgdwu_pkg::clamp32(sum3);

    logic [31:0] w3_reg, v3d_reg, r3_reg;
    logic        sat3_reg;

    // stage 4: momentum adds the clamped velocity to the weight
    logic [sgdwu_pkg::SUM_W-1:0] sum4;
    sgdwu_pkg::clamp_t           c4;

    assign sum4 = {{10{w3_reg[31]}}, w3_reg} + {{10{r3_reg[31]}}, r3_reg};
    assign c4   = sgdwu_pkg::clamp32(sum4);

    logic [31:0] wo_reg, vo_reg;
    logic        sat_reg;

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            w1_reg  <= w_in;
            v1d_reg <= v_in;
            pg1_reg <= pg_full;
            pd1_reg <= pd_full;
            pm1_reg <= pm_full;
        end
        if (ld2)
        begin
            w2_reg  <= w1_reg;
            v2d_reg <= v1d_reg;
            gt2_reg <= pg_rnd[63:24];
            dt2_reg <= pd_rnd[63:24];
            mt2_reg <= pm_rnd[56:24];
        end
        if (ld3)
        begin
            w3_reg   <= w2_reg;
            v3d_reg  <= v2d_reg;
            r3_reg   <= c3.val;
            sat3_reg <= c3.sat;
        end
        if (ld4)
        begin
            if (use_momentum_reg)
            begin
                wo_reg  <= c4.val;
                vo_reg  <= r3_reg;
                sat_reg <= sat3_reg || c4.sat;
            end
            else
            begin
                wo_reg  <= r3_reg;
                vo_reg  <= v3d_reg;
                sat_reg <= sat3_reg;
            end
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {vo_reg, wo_reg};
    assign m_tuser  = sat_reg;

`ifndef SYNTHESIS
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted word did not enter stage 1");

    a_s3_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !ld4 |=> v3_reg && $stable(r3_reg) && $stable(sat3_reg))
        else $error("stage 3 changed while stage 4 was stalled");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && sat_reg |->
            (wo_reg == 32'h7FFF_FFFF) || (wo_reg == 32'h8000_0000) ||
            (vo_reg == 32'h7FFF_FFFF) || (vo_reg == 32'h8000_0000))
        else $error("saturated flag set with no result at a limit");
`endif

endmodule

### tb/sv/weight_update_checker.sv
`timescale 1ns / 100ps
// Checker for the SGD weight update unit: predicts each update and compares result words.
module weight_update_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,   // weight_in, velocity_in, gradient_sum
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // weight_out, velocity_out
    input  logic        m_tuser,   // saturated
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatch_count,
    output int          updates_in_flight
);

    typedef struct packed {
        logic        sat;
        logic [31:0] velocity;
        logic [31:0] weight;
    } update_t;

    localparam longint signed WORD_MAX = 64'sd2147483647;
    localparam longint signed WORD_MIN = -64'sd2147483648;

    logic [1:0]  decay_mode;
    logic        momentum_on;
    logic [31:0] grad_k;
    logic [31:0] decay_k;
    logic [23:0] mu_k;

    update_t expected_updates[$];

    // scale * x / 2^24, rounded half up
    function automatic longint signed scale_round(input logic [31:0] k, input longint signed x);
        longint signed p;
        p = $signed({32'd0, k}) * x;
        return (p + (64'sd1 <<< (sgdwu_pkg::SCALE_BITS - 1))) >>> sgdwu_pkg::SCALE_BITS;
    endfunction

    function automatic longint signed clip_word(input longint signed x, output logic hit);
        hit = 1'b1;
        if (x > WORD_MAX)
            return WORD_MAX;
        if (x < WORD_MIN)
            return WORD_MIN;
        hit = 1'b0;
        return x;
    endfunction

    function automatic update_t predict_update(input logic [95:0] word);
        longint signed w, v, g, unit, gterm, dterm, v_new, w_new;
        logic hit_v, hit_w;
        update_t r;
        w = $signed(word[31:0]);
        v = $signed(word[63:32]);
        g = $signed(word[95:64]);
        unit = 64'sd1 <<< FRAC_BITS;
        gterm = scale_round(grad_k, g);
        dterm = 0;
        if (decay_mode == sgdwu_pkg::REG_L1)
            dterm = scale_round(decay_k, (w > 0) ? unit : ((w < 0) ? -unit : 64'sd0));
        else if (decay_mode == sgdwu_pkg::REG_L2)
            dterm = scale_round(decay_k, w);
        hit_v = 1'b0;
        if (momentum_on)
        begin
            // clamp velocity first, then add the clamped value to the weight
            v_new = clip_word(scale_round({8'd0, mu_k}, v) - gterm - dterm, hit_v);
            w_new = clip_word(w + v_new, hit_w);
        end
        else
        begin
            v_new = v;
            w_new = clip_word(w - gterm - dterm, hit_w);
        end
        r.weight   = w_new[31:0];
        r.velocity = v_new[31:0];
        r.sat      = hit_v | hit_w;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        update_t got;
        update_t want;
        if (!rst_n)
        begin
            decay_mode  = sgdwu_pkg::REG_NONE;
            momentum_on = 1'b0;
            grad_k      = '0;
            decay_k     = '0;
            mu_k        = '0;
            expected_updates.delete();
            updates_in_flight = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sgdwu_pkg::CFG_REG_MODE:        decay_mode  = cfg_data[1:0];
                    sgdwu_pkg::CFG_USE_MOMENTUM:    momentum_on = cfg_data[0];
                    sgdwu_pkg::CFG_GRAD_SCALE:      grad_k      = cfg_data;
                    sgdwu_pkg::CFG_DECAY_SCALE:     decay_k     = cfg_data;
                    sgdwu_pkg::CFG_MOMENTUM_FACTOR: mu_k        = cfg_data[23:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser, m_tdata[63:32], m_tdata[31:0]};
                if (expected_updates.size() == 0)
                begin
                    $error("result word with no update pending: %h %b", m_tdata, m_tuser);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_updates.pop_front();
                    if (got.weight !== want.weight)
                    begin
                        $error("weight_out: expected %h, got %h", want.weight, got.weight);
                        mismatch_count++;
                    end
                    if (got.velocity !== want.velocity)
                    begin
                        $error("velocity_out: expected %h, got %h", want.velocity, got.velocity);
                        mismatch_count++;
                    end
                    if (got.sat !== want.sat)
                    begin
                        $error("saturated: expected %b, got %b", want.sat, got.sat);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_updates.insert(expected_updates.size(), predict_update(s_tdata));
            updates_in_flight = expected_updates.size();
        end
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench top for the SGD weight update unit: stimulus, configuration writes and verdict.
module tb;

    localparam int FRAC_BITS       = 16;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int HOLD_OFF_CYCLES = 300;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata   = '0;   // weight_in, velocity_in, gradient_sum
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;          // weight_out, velocity_out
    logic        m_tuser;          // saturated
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    int mismatch_count;
    int updates_in_flight;
    int cycle_count = 0;
    bit calm        = 1'b0;
    bit stall_req   = 1'b0;

    sgd_weight_update_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    weight_update_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .updates_in_flight(updates_in_flight)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sgd_weight_update_unit: mismatch");
            $finish;
        end
    end

    // mostly short idles, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 92)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        if (calm || $urandom_range(0, 99) < 55)
            return 0;
        return idle_len();
    endfunction

    function automatic logic [31:0] pick_field();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom_range(0, 32'h1_FFFF) - 32'h1_0000;
            3:       return $urandom_range(0, 2) - 1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(0, 4))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 32'h0100_0000);
            3:       return $urandom_range(0, 32'h0010_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] pick_mu();
        case ($urandom_range(0, 2))
            0:       return 24'h0;
            1:       return 24'hFF_FFFF;
            default: return 24'($urandom_range(0, 24'hFF_FFFF));
        endcase
    endfunction

    // enter and leave at a falling edge; hold the word until it is taken
    task automatic send_fields(input logic [31:0] w, input logic [31:0] v, input logic [31:0] g);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {g, v, w};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random();
        send_fields(pick_field(), pick_field(), pick_field());
    endtask

    task automatic write_settings(input logic [1:0] mode, input logic mom,
                                  input logic [31:0] gs, input logic [31:0] ds,
                                  input logic [23:0] mu);
        cfg_we    <= 1'b1;
        cfg_index <= sgdwu_pkg::CFG_REG_MODE;
        cfg_data  <= {30'd0, mode};
        @(negedge clk);
        cfg_index <= sgdwu_pkg::CFG_USE_MOMENTUM;
        cfg_data  <= {31'd0, mom};
        @(negedge clk);
        cfg_index <= sgdwu_pkg::CFG_GRAD_SCALE;
        cfg_data  <= gs;
        @(negedge clk);
        cfg_index <= sgdwu_pkg::CFG_DECAY_SCALE;
        cfg_data  <= ds;
        @(negedge clk);
        cfg_index <= sgdwu_pkg::CFG_MOMENTUM_FACTOR;
        cfg_data  <= {8'd0, mu};
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // drop valid and wait for every pending update to come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (updates_in_flight != 0)
            @(negedge clk);
    endtask

    initial
    begin : receiver
        int rx_wait;
        bit held;
        rx_wait = 0;
        held    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req && !held)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                held = 1'b1;
            end
            if (rx_wait > 0)
            begin
                m_tready <= 1'b0;
                rx_wait--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    rx_wait = idle_len();
            end
        end
    end

    initial
    begin : stimulus
        int p;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings leave weights untouched
        repeat (3) send_random();
        drain();

        // L1 decay, plain update, gradient scale one half for rounding ties
        write_settings(sgdwu_pkg::REG_L1, 1'b0, 32'h0080_0000, 32'h0100_0000, 24'd0);
        send_fields(32'd0, 32'd0, 32'd1);
        send_fields(32'd0, 32'd0, 32'hFFFF_FFFF);
        send_fields(32'd100, 32'd5, 32'd0);
        send_fields(-32'd100, -32'd5, 32'd0);
        send_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_fields(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_fields(32'h0001_0000, 32'h1234_5678, 32'h0000_0003);
        drain();

        // L2 momentum with every scale at its top: velocity clamps, then weight
        write_settings(sgdwu_pkg::REG_L2, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_fields(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_fields(32'd0, 32'd0, 32'd0);
        send_fields(32'd1, 32'hFFFF_FFFF, 32'd1);
        send_fields(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0);
        send_fields(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        drain();

        // unused mode code behaves as no decay
        write_settings(2'd3, 1'b1, 32'h0100_0000, 32'hFFFF_FFFF, 24'h80_0000);
        send_fields(32'd1000, 32'd3, 32'd5);
        send_fields(-32'd1000, -32'd3, -32'd5);
        send_fields(32'd0, 32'd1, 32'd1);
        send_fields(32'h7FFF_FFFF, 32'd0, 32'd0);
        drain();

        for (p = 0; p < 12; p++)
        begin
            calm = (p % 4 == 3);
            if (p == 0)
                write_settings(sgdwu_pkg::REG_NONE, 1'b0, 32'h0, 32'h0, 24'h0);
            else if (p == 1)
                write_settings(sgdwu_pkg::REG_L2, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               24'hFF_FFFF);
            else
                write_settings(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               pick_scale(), pick_scale(), pick_mu());
            repeat (115) send_random();
            drain();
        end
        calm = 1'b0;

        // hold the output off while words keep coming, so the input backs up
        write_settings(sgdwu_pkg::REG_L1, 1'b1, pick_scale(), pick_scale(), pick_mu());
        stall_req = 1'b1;
        repeat (40) send_random();
        drain();

        repeat (10) @(negedge clk);
        if (mismatch_count == 0)
            $display("sgd_weight_update_unit: match");
        else
            $display("sgd_weight_update_unit: mismatch");
        $finish;
    end

endmodule
